// File: design/ray_sphere_path_split_core_defines.svh
// Assertion macros shared by the checker of the path split core.
`ifndef RAY_SPHERE_PATH_SPLIT_CORE_DEFINES_SVH
`define RAY_SPHERE_PATH_SPLIT_CORE_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define RSPS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("path split core: invariant violated");

// Same-cycle implication.
`define RSPS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("path split core: implication violated");

// Next-cycle implication.
`define RSPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("path split core: sequence violated");

`endif

// File: design/rsps_pkg.sv
// Types and constants of the ray/sphere path split core.
package rsps_pkg;

  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 23;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_RAD_W   = 54;
  localparam int SQ_ROOT_W  = SQ_RAD_W / 2;
  localparam int SQ_REM_W   = SQ_ROOT_W + 3;
  localparam int DV_W       = 51;
  localparam int DV_Q_W     = 26;
  localparam int LEN_W      = DV_W - DV_Q_W + 1;

  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_CZ     = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] total_length;
    logic [COORD_W-1:0] inside_length;
    logic [COORD_W-1:0] outside_length;
  } out_t;

  // square root digit recurrence state
  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_t;

  // restoring divider state
  typedef struct packed {
    logic [DV_W-1:0]   rem;
    logic [DV_W-1:0]   dvs;
    logic [DV_Q_W-1:0] quo;
  } dv_t;

endpackage

// File: design/rsps_sqrt_cell.sv
// One root bit of the integer square root chain.
module rsps_sqrt_cell import rsps_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  d_i,
  output sq_t  q_o
);

  sq_t stage_d, stage_q;
  logic [SQ_REM_W-1:0] cur, trial;
  logic ge;

  always_comb begin
    cur   = {d_i.rem[SQ_REM_W-3:0], d_i.rad[SQ_RAD_W-1 -: 2]};
    trial = {1'b0, d_i.root, 2'b01};
    ge    = (cur >= trial);
    stage_d.rad  = {d_i.rad[SQ_RAD_W-3:0], 2'b00};
    stage_d.rem  = ge ? (cur - trial) : cur;
    stage_d.root = {d_i.root[SQ_ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign q_o = stage_q;

endmodule

// File: design/rsps_div_cell.sv
// One quotient bit of the restoring divider chain.
module rsps_div_cell import rsps_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  dv_t  d_i,
  output dv_t  q_o
);

  dv_t stage_d, stage_q;
  logic ge;

  always_comb begin
    ge          = (d_i.rem >= d_i.dvs);
    stage_d.rem = ge ? (d_i.rem - d_i.dvs) : d_i.rem;
    stage_d.dvs = {1'b0, d_i.dvs[DV_W-1:1]};
    stage_d.quo = {d_i.quo[DV_Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign q_o = stage_q;

endmodule

// File: design/ray_sphere_path_split_core.sv
// Top level: segment length and inside/outside split against a sphere.
//
//  channel   dir   handshake                 payload
//  in        in    in_valid_i / in_ready_o   in_data_i  (in_t)
//  out       out   out_valid_o / out_ready_i out_data_o (out_t)
//  cfg       in    psel/penable/pwrite       paddr, pwdata, prdata
//
// One transaction per cycle unless the output stalls; the pipeline is built
// from the two 27-cell square root chains and the 26-cell divider chain.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and out_ready_i is low, and in_ready_o then drops.
// Reset clears the valid bits and restores radius 4.25 m, centre z 0.
module ray_sphere_path_split_core import rsps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NSQ = SQ_ROOT_W;
  localparam int NDV = DV_Q_W;

  logic en;
  logic [RADIUS_W-1:0]       radius_q;
  logic signed [COORD_W-1:0] cz_q;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_W'(278528);
      cz_q     <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_RADIUS: radius_q <= pwdata[RADIUS_W-1:0];
        REG_CZ:     cz_q     <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_CZ) ? {{(32-COORD_W){cz_q[COORD_W-1]}}, cz_q}
                                       : {{(32-RADIUS_W){1'b0}}, radius_q};

  logic out_valid_q;
  out_t out_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // stage 1: differences
  logic v1_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q, vx_q, vy_q, vz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= {in_data_i.end_x[COORD_W-1], in_data_i.end_x}
            - {in_data_i.start_x[COORD_W-1], in_data_i.start_x};
      dy_q <= {in_data_i.end_y[COORD_W-1], in_data_i.end_y}
            - {in_data_i.start_y[COORD_W-1], in_data_i.start_y};
      dz_q <= {in_data_i.end_z[COORD_W-1], in_data_i.end_z}
            - {in_data_i.start_z[COORD_W-1], in_data_i.start_z};
      vx_q <= DIFF_W'(0) - {in_data_i.start_x[COORD_W-1], in_data_i.start_x};
      vy_q <= DIFF_W'(0) - {in_data_i.start_y[COORD_W-1], in_data_i.start_y};
      vz_q <= {cz_q[COORD_W-1], cz_q}
            - {in_data_i.start_z[COORD_W-1], in_data_i.start_z};
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [2*DIFF_W-1:0] dd_q [3];
  logic signed [2*DIFF_W-1:0] dv_q [3];
  logic signed [2*DIFF_W-1:0] vv_q [3];
  logic [2*RADIUS_W-1:0]      rr_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= dx_q * dx_q;
      dd_q[1] <= dy_q * dy_q;
      dd_q[2] <= dz_q * dz_q;
      dv_q[0] <= dx_q * vx_q;
      dv_q[1] <= dy_q * vy_q;
      dv_q[2] <= dz_q * vz_q;
      vv_q[0] <= vx_q * vx_q;
      vv_q[1] <= vy_q * vy_q;
      vv_q[2] <= vz_q * vz_q;
      rr_q    <= radius_q * radius_q;
    end
  end

  // stage 3: dot products
  logic v3_q;
  logic [2*DIFF_W-1:0]       d2_q;
  logic signed [DV_W-1:0]    p3_q, c3_q;
  logic [2*DIFF_W-1:0]       vsum;
  always_comb begin
    vsum = $unsigned(vv_q[0]) + $unsigned(vv_q[1]) + $unsigned(vv_q[2]);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q <= $unsigned(dd_q[0]) + $unsigned(dd_q[1]) + $unsigned(dd_q[2]);
      p3_q <= DV_W'(dv_q[0]) + DV_W'(dv_q[1]) + DV_W'(dv_q[2]);
      c3_q <= $signed({1'b0, vsum}) - $signed({{(DV_W-2*RADIUS_W){1'b0}}, rr_q});
    end
  end

  // chain 1: length = isqrt(d2)
  sq_t  sq1 [NSQ+1];
  logic s1_v_q    [NSQ+1];
  logic s1_zero_q [NSQ+1];
  logic signed [DV_W-1:0] s1_p_q [NSQ+1];
  logic signed [DV_W-1:0] s1_c_q [NSQ+1];

  assign sq1[0].rad  = SQ_RAD_W'(d2_q);
  assign sq1[0].rem  = '0;
  assign sq1[0].root = '0;
  always_comb begin
    s1_v_q[0]    = v3_q;
    s1_zero_q[0] = (d2_q == '0);
    s1_p_q[0]    = p3_q;
    s1_c_q[0]    = c3_q;
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq1
    rsps_sqrt_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(sq1[i]), .q_o(sq1[i+1]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_v_q[i+1] <= 1'b0;
      end else if (en) begin
        s1_v_q[i+1] <= s1_v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_zero_q[i+1] <= s1_zero_q[i];
        s1_p_q[i+1]    <= s1_p_q[i];
        s1_c_q[i+1]    <= s1_c_q[i];
      end
    end
  end

  // chain 2: |t| = |p| / length
  logic [LEN_W-1:0] len1;
  logic             pneg1;
  assign len1  = sq1[NSQ].root[LEN_W-1:0];
  assign pneg1 = s1_p_q[NSQ][DV_W-1];

  dv_t  dv [NDV+1];
  logic s2_v_q    [NDV+1];
  logic s2_zero_q [NDV+1];
  logic s2_pneg_q [NDV+1];
  logic signed [DV_W-1:0] s2_c_q [NDV+1];
  logic [LEN_W-1:0]       s2_len_q [NDV+1];

  assign dv[0].rem = pneg1 ? $unsigned(-s1_p_q[NSQ]) : $unsigned(s1_p_q[NSQ]);
  assign dv[0].dvs = {len1, (DV_Q_W-1)'(0)};
  assign dv[0].quo = '0;
  always_comb begin
    s2_v_q[0]    = s1_v_q[NSQ];
    s2_zero_q[0] = s1_zero_q[NSQ];
    s2_pneg_q[0] = pneg1;
    s2_c_q[0]    = s1_c_q[NSQ];
    s2_len_q[0]  = len1;
  end

  for (genvar i = 0; i < NDV; i++) begin : g_dv
    rsps_div_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(dv[i]), .q_o(dv[i+1]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s2_v_q[i+1] <= 1'b0;
      end else if (en) begin
        s2_v_q[i+1] <= s2_v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s2_zero_q[i+1] <= s2_zero_q[i];
        s2_pneg_q[i+1] <= s2_pneg_q[i];
        s2_c_q[i+1]    <= s2_c_q[i];
        s2_len_q[i+1]  <= s2_len_q[i];
      end
    end
  end

  // stage 4: t and t*t
  logic v4_q, zero4_q;
  logic signed [DV_Q_W:0]  t4_q;
  logic [2*DV_Q_W-1:0]     tt4_q;
  logic signed [DV_W-1:0]  c4_q;
  logic [LEN_W-1:0]        len4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q    <= s2_pneg_q[NDV] ? -$signed({1'b0, dv[NDV].quo})
                                : $signed({1'b0, dv[NDV].quo});
      tt4_q   <= dv[NDV].quo * dv[NDV].quo;
      c4_q    <= s2_c_q[NDV];
      len4_q  <= s2_len_q[NDV];
      zero4_q <= s2_zero_q[NDV];
    end
  end

  // stage 5: discriminant
  logic v5_q, zero5_q, nodisc5_q;
  logic signed [SQ_RAD_W-1:0] disc5_q;
  logic signed [SQ_RAD_W-1:0] disc;
  logic signed [DV_Q_W:0]     t5_q;
  logic [LEN_W-1:0]           len5_q;
  assign disc = $signed({{(SQ_RAD_W-2*DV_Q_W){1'b0}}, tt4_q}) - SQ_RAD_W'(c4_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      disc5_q   <= disc;
      nodisc5_q <= disc[SQ_RAD_W-1] || (disc == '0);
      t5_q      <= t4_q;
      len5_q    <= len4_q;
      zero5_q   <= zero4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= s2_v_q[NDV];
      v5_q <= v4_q;
    end
  end

  // chain 3: q = isqrt(disc)
  sq_t  sq2 [NSQ+1];
  logic s3_v_q      [NSQ+1];
  logic s3_zero_q   [NSQ+1];
  logic s3_nodisc_q [NSQ+1];
  logic signed [DV_Q_W:0] s3_t_q   [NSQ+1];
  logic [LEN_W-1:0]       s3_len_q [NSQ+1];

  assign sq2[0].rad  = $unsigned(disc5_q);
  assign sq2[0].rem  = '0;
  assign sq2[0].root = '0;
  always_comb begin
    s3_v_q[0]      = v5_q;
    s3_zero_q[0]   = zero5_q;
    s3_nodisc_q[0] = nodisc5_q;
    s3_t_q[0]      = t5_q;
    s3_len_q[0]    = len5_q;
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq2
    rsps_sqrt_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(sq2[i]), .q_o(sq2[i+1]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s3_v_q[i+1] <= 1'b0;
      end else if (en) begin
        s3_v_q[i+1] <= s3_v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s3_zero_q[i+1]   <= s3_zero_q[i];
        s3_nodisc_q[i+1] <= s3_nodisc_q[i];
        s3_t_q[i+1]      <= s3_t_q[i];
        s3_len_q[i+1]    <= s3_len_q[i];
      end
    end
  end

  // final split and saturation
  localparam int FW = SQ_ROOT_W + 2;
  logic signed [FW-1:0] dplus, lens, chord, inner, outside;
  logic hit;
  out_t out_d;

  function automatic logic [COORD_W-1:0] sat(input logic signed [FW-1:0] v);
    logic [COORD_W-1:0] r;
    if (v <= 0) r = '0;
    else if (v > $signed({{(FW-COORD_W){1'b0}}, {COORD_W{1'b1}}})) r = '1;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  always_comb begin
    dplus   = FW'(s3_t_q[NSQ]) + $signed({2'b00, sq2[NSQ].root});
    lens    = $signed({{(FW-LEN_W){1'b0}}, s3_len_q[NSQ]});
    chord   = $signed({1'b0, sq2[NSQ].root, 1'b0});
    hit     = !s3_nodisc_q[NSQ] && (dplus > 0) && (dplus < lens);
    inner   = hit ? ((dplus <= chord) ? dplus : chord) : '0;
    outside = lens - inner;
    if (s3_zero_q[NSQ]) begin
      out_d = '0;
    end else begin
      out_d.total_length   = sat(lens);
      out_d.inside_length  = sat(inner);
      out_d.outside_length = sat(outside);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_v_q[NSQ];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// File: design/rsps_checker.sv
// Port-level checks for the path split core, bound to the top level.
`include "ray_sphere_path_split_core_defines.svh"
module rsps_checker import rsps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o,
  input logic        pready
);

  logic [COORD_W:0] split_sum;
  logic [COORD_W:0] total_ext;
  assign split_sum = {1'b0, out_data_o.inside_length} + {1'b0, out_data_o.outside_length};
  assign total_ext = {1'b0, out_data_o.total_length};

  `RSPS_ASSERT_ALWAYS(a_pready_high, pready)
  // input side stalls only while a result held in the output register waits and out_ready_i is low
  `RSPS_ASSERT_ALWAYS(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i))
  // unsaturated parts add up to the length
  `RSPS_ASSERT_IMPL(a_split_sum, out_valid_o && (out_data_o.total_length != '1), split_sum == total_ext)
  `RSPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind ray_sphere_path_split_core rsps_checker u_rsps_checker (.*);
